>>> rtl/clebu_pkg.sv
// clebu_pkg: shared types and constants for the cursor line edit buffer
// used by clebu_front, clebu_back and cursor_line_edit_buffer_unit
// no dependencies
package clebu_pkg;

  // buffer geometry
  localparam int BUF_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int IDX_W     = 10;
  localparam int CHAR_W    = 8;

  // command op codes
  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_LEFT      = 3'd1;
  localparam logic [2:0] OP_RIGHT     = 3'd2;
  localparam logic [2:0] OP_BACKSPACE = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_BOUNDARY = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  // input word
  typedef struct packed {
    logic [2:0]        op;
    logic [CHAR_W-1:0] char_in;
    logic [IDX_W-1:0]  read_index;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [CNT_W-1:0]  text_length;
    logic [CNT_W-1:0]  cursor_pos;
    logic [1:0]        status;
  } out_word_t;

  // classified command kinds
  typedef enum logic [2:0] {
    K_INSERT,
    K_LEFT,
    K_RIGHT,
    K_BACK,
    K_READ,
    K_NOP
  } cmd_kind_t;

  // queued command
  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] char_in;
    logic [IDX_W-1:0]  read_index;
  } cmd_t;

  // queue head towards the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

>>> rtl/clebu_front.sv
// clebu_front: accepts command words, classifies them and queues them
// depends on clebu_pkg
module clebu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  clebu_pkg::in_word_t in_word,
  output clebu_pkg::q_head_t  q_head,
  input  logic               q_pop
);

  clebu_pkg::cmd_t q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  clebu_pkg::cmd_t   cmd_in;

  // classify the incoming op
  always_comb begin
    cmd_in.char_in    = in_word.char_in;
    cmd_in.read_index = in_word.read_index;
    unique case (in_word.op)
      clebu_pkg::OP_INSERT:    cmd_in.kind = clebu_pkg::K_INSERT;
      clebu_pkg::OP_LEFT:      cmd_in.kind = clebu_pkg::K_LEFT;
      clebu_pkg::OP_RIGHT:     cmd_in.kind = clebu_pkg::K_RIGHT;
      clebu_pkg::OP_BACKSPACE: cmd_in.kind = clebu_pkg::K_BACK;
      clebu_pkg::OP_READ:      cmd_in.kind = clebu_pkg::K_READ;
      default:                 cmd_in.kind = clebu_pkg::K_NOP;
    endcase
  end

  // two-entry queue control
  assign busy  = (count_r == 2'd2);
  assign push  = start && !busy;
  assign pop   = q_pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  // head of queue
  assign q_head.valid = (count_r != 2'd0);
  assign q_head.cmd   = q_mem_r[rd_ptr_r];

endmodule

>>> rtl/clebu_back.sv
// clebu_back: carries out queued commands on the left and right stores
// depends on clebu_pkg
module clebu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  clebu_pkg::q_head_t   q_head,
  output logic                q_pop,
  output logic                out_strobe,
  output clebu_pkg::out_word_t out_word
);

  localparam int A = clebu_pkg::ADDR_W;
  localparam int C = clebu_pkg::CNT_W;
  localparam int W = clebu_pkg::CHAR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_L,
    S_MOVE_R,
    S_READ_L,
    S_READ_R
  } state_t;

  state_t   state_r, state_nxt;
  logic [C-1:0] lc_r, lc_nxt;
  logic [C-1:0] rc_r, rc_nxt;
  logic         strobe_r, strobe_nxt;
  clebu_pkg::out_word_t res_r, res_nxt;

  logic [W-1:0] left_mem  [clebu_pkg::BUF_DEPTH];
  logic [W-1:0] right_mem [clebu_pkg::BUF_DEPTH];
  logic [W-1:0] lrd_r, rrd_r;

  logic         lwe, rwe, lre, rre;
  logic [A-1:0] lwa, rwa, lra, rra;
  logic [W-1:0] lwd, rwd;

  logic [C-1:0] total;
  logic [C-1:0] lc_m1, rc_m1;
  logic [C-1:0] idx_ext;
  logic [C-1:0] rpos;
  logic         emit;
  logic [1:0]   st_v;
  logic [W-1:0] ch_v;

  assign total   = lc_r + rc_r;
  assign lc_m1   = lc_r - C'(1);
  assign rc_m1   = rc_r - C'(1);
  assign idx_ext = C'(q_head.cmd.read_index);
  assign rpos    = total - C'(1) - idx_ext;

  // command sequencer
  always_comb begin
    state_nxt  = state_r;
    lc_nxt     = lc_r;
    rc_nxt     = rc_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    q_pop      = 1'b0;
    lwe        = 1'b0;
    rwe        = 1'b0;
    lre        = 1'b0;
    rre        = 1'b0;
    lwa        = lc_r[A-1:0];
    rwa        = rc_r[A-1:0];
    lra        = A'(q_head.cmd.read_index);
    rra        = rpos[A-1:0];
    lwd        = q_head.cmd.char_in;
    rwd        = lrd_r;
    emit       = 1'b0;
    st_v       = clebu_pkg::ST_DONE;
    ch_v       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          unique case (q_head.cmd.kind)
            clebu_pkg::K_INSERT: begin
              emit = 1'b1;
              if (total >= C'(clebu_pkg::BUF_DEPTH)) begin
                st_v = clebu_pkg::ST_FULL;
              end else begin
                lwe    = 1'b1;
                lc_nxt = lc_r + C'(1);
              end
            end
            clebu_pkg::K_LEFT: begin
              if (lc_r == '0) begin
                emit = 1'b1;
                st_v = clebu_pkg::ST_BOUNDARY;
              end else begin
                lre       = 1'b1;
                lra       = lc_m1[A-1:0];
                state_nxt = S_MOVE_L;
              end
            end
            clebu_pkg::K_RIGHT: begin
              if (rc_r == '0) begin
                emit = 1'b1;
                st_v = clebu_pkg::ST_BOUNDARY;
              end else begin
                rre       = 1'b1;
                rra       = rc_m1[A-1:0];
                state_nxt = S_MOVE_R;
              end
            end
            clebu_pkg::K_BACK: begin
              emit = 1'b1;
              if (lc_r == '0) begin
                st_v = clebu_pkg::ST_BOUNDARY;
              end else begin
                lc_nxt = lc_m1;
              end
            end
            clebu_pkg::K_READ: begin
              if (idx_ext < lc_r) begin
                lre       = 1'b1;
                state_nxt = S_READ_L;
              end else if (idx_ext < total) begin
                rre       = 1'b1;
                state_nxt = S_READ_R;
              end else begin
                emit = 1'b1;
                st_v = clebu_pkg::ST_RANGE;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      // byte left of cursor moves onto the right stack
      S_MOVE_L: begin
        rwe       = 1'b1;
        lc_nxt    = lc_m1;
        rc_nxt    = rc_r + C'(1);
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      // top of right stack moves to the left store
      S_MOVE_R: begin
        lwe       = 1'b1;
        lwd       = rrd_r;
        lc_nxt    = lc_r + C'(1);
        rc_nxt    = rc_m1;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_READ_L: begin
        ch_v      = lrd_r;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_READ_R: begin
        ch_v      = rrd_r;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // result word from the updated counts
    if (emit) begin
      strobe_nxt          = 1'b1;
      res_nxt.char_out    = ch_v;
      res_nxt.text_length = lc_nxt + rc_nxt;
      res_nxt.cursor_pos  = lc_nxt;
      res_nxt.status      = st_v;
    end
  end

  // state, counts and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      lc_r     <= '0;
      rc_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      lc_r     <= lc_nxt;
      rc_r     <= rc_nxt;
      strobe_r <= strobe_nxt;
      res_r    <= res_nxt;
    end
  end

  // left store
  always_ff @(posedge clk) begin
    if (lwe) begin
      left_mem[lwa] <= lwd;
    end
    if (lre) begin
      lrd_r <= left_mem[lra];
    end
  end

  // right store, kept as a stack
  always_ff @(posedge clk) begin
    if (rwe) begin
      right_mem[rwa] <= rwd;
    end
    if (rre) begin
      rrd_r <= right_mem[rra];
    end
  end

  assign out_strobe = strobe_r;
  assign out_word   = res_r;

endmodule

>>> rtl/cursor_line_edit_buffer_unit.sv
// cursor_line_edit_buffer_unit: top level of the gap buffer line editor
// depends on clebu_pkg, clebu_front and clebu_back
//
//  channel   ports                       handshake
//  command   start, busy, in_word        taken when start high and busy low
//  result    out_strobe, out_word        one cycle per word, cannot be held off
//
// insert, backspace and every rejected command answer from the idle state;
// cursor moves and reads pass a move or read state first, as the stores have
// one registered read port each and the back end runs one command at a time
// a two-word queue lets commands be taken while the back end works; busy
// is high only when that queue is full
// reset clears the counts and the queue; store contents are left as they are
module cursor_line_edit_buffer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  clebu_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output clebu_pkg::out_word_t out_word
);

  clebu_pkg::q_head_t q_head;
  logic              q_pop;

  // command intake and queue
  clebu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // command execution
  clebu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
